FILE: sv/bdr_pkg.sv
// ----------------------------------------------------------------------------
// bdr_pkg
// Shared types and constants for the boost duty regulator: command codes,
// register map, loop gains and the structs passed between the stages.
// ----------------------------------------------------------------------------
`default_nettype none

package bdr_pkg;

    // command codes
    localparam logic [3:0] CMD_NONE      = 4'd0;
    localparam logic [3:0] CMD_DUTY_DOWN = 4'd1;
    localparam logic [3:0] CMD_DUTY_UP   = 4'd2;
    localparam logic [3:0] CMD_REG_ON    = 4'd3;
    localparam logic [3:0] CMD_REG_OFF   = 4'd4;
    localparam logic [3:0] CMD_SP_UP     = 4'd5;
    localparam logic [3:0] CMD_SP_DOWN   = 4'd6;
    localparam logic [3:0] CMD_PSC_UP    = 4'd7;
    localparam logic [3:0] CMD_PSC_DOWN  = 4'd8;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_OC_THR    = 3'd0;
    localparam logic [2:0] REG_DUTY_MIN  = 3'd1;
    localparam logic [2:0] REG_DUTY_MAX  = 3'd2;
    localparam logic [2:0] REG_DUTY_STEP = 3'd3;
    localparam logic [2:0] REG_DUTY_DEF  = 3'd4;
    localparam logic [2:0] REG_PSC_MIN   = 3'd5;
    localparam logic [2:0] REG_PSC_MAX   = 3'd6;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // register reset values
    localparam logic [11:0] RST_OC_THR    = 12'd3723;
    localparam logic [13:0] RST_DUTY_MIN  = 14'd72;
    localparam logic [13:0] RST_DUTY_MAX  = 14'd10080;
    localparam logic [11:0] RST_DUTY_STEP = 12'd72;
    localparam logic [13:0] RST_DUTY_DEF  = 14'd7200;
    localparam logic [7:0]  RST_PSC_MIN   = 8'd1;
    localparam logic [7:0]  RST_PSC_MAX   = 8'd30;

    // state reset values
    localparam logic [7:0]  RST_PSC       = 8'd12;
    localparam logic [7:0]  RST_SETPOINT  = 8'd48;

    // loop gains: 3.3 * 10.83 * 3000 per full-scale sample, 3000 / 2 per half volt
    localparam int          CORR_W        = 17;
    localparam logic [16:0] VOLT_GAIN     = 17'd107217;
    localparam int          ACC_W         = 21;
    localparam logic [10:0] SP_GAIN       = 11'd1500;

    typedef struct packed {
        logic [11:0] oc_threshold;
        logic [13:0] duty_min;
        logic [13:0] duty_max;
        logic [11:0] duty_step;
        logic [13:0] duty_default;
        logic [7:0]  psc_min;
        logic [7:0]  psc_max;
    } t_cfg;

    typedef struct packed {
        logic [3:0]        cmd;
        logic              oc;
        logic [CORR_W-1:0] corr;
    } t_item;

endpackage

`default_nettype wire

FILE: sv/bdr_front.sv
// ----------------------------------------------------------------------------
// bdr_front
// Input register: takes a word, compares the current sample against the
// threshold and forms the voltage correction term for the core.
// ----------------------------------------------------------------------------
`default_nettype none

module bdr_front #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_stall,
    input  wire [3:0]             i_new_command,
    input  wire [SAMPLE_BITS-1:0] i_current_sample,
    input  wire [SAMPLE_BITS-1:0] i_voltage_sample,
    input  wire [11:0]            i_threshold,
    input  wire                   i_take,
    output logic                  o_valid,
    output bdr_pkg::t_item        o_item
);
    import bdr_pkg::*;

    localparam int CMP_W  = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
    localparam int PROD_W = CORR_W + SAMPLE_BITS + 1;

    logic              r_valid;
    t_item             r_item;
    t_item             n_item;
    logic              load_en;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] prod_up;

    assign load_en = !r_valid || i_take;
    assign o_stall = !load_en;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // ceil(gain * v / 2^SAMPLE_BITS)
    assign prod    = PROD_W'(VOLT_GAIN) * PROD_W'(i_voltage_sample);
    assign prod_up = prod + {{(PROD_W-SAMPLE_BITS){1'b0}}, {SAMPLE_BITS{1'b1}}};

    always_comb begin
        n_item.cmd  = i_new_command;
        n_item.oc   = CMP_W'(i_current_sample) > CMP_W'(i_threshold);
        n_item.corr = CORR_W'(prod_up >> SAMPLE_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_en && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

FILE: sv/bdr_core.sv
// ----------------------------------------------------------------------------
// bdr_core
// Loop state and result register: pending command slot, command execution,
// proportional duty update with clamping, and the registered result word.
// ----------------------------------------------------------------------------
`default_nettype none

module bdr_core (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  bdr_pkg::t_cfg   i_cfg,
    input  wire             i_valid,
    input  bdr_pkg::t_item  i_item,
    output logic            o_take,
    output logic            o_out_valid,
    input  wire             i_out_stall,
    output logic [13:0]     o_duty_compare,
    output logic [7:0]      o_inverter_prescaler,
    output logic            o_regulating,
    output logic            o_overcurrent,
    output logic [7:0]      o_setpoint_half_volts
);
    import bdr_pkg::*;

    logic [13:0] r_duty;
    logic [7:0]  r_psc;
    logic        r_reg_on;
    logic [7:0]  r_sp;
    logic [3:0]  r_pend;

    logic [13:0] n_duty;
    logic [7:0]  n_psc;
    logic        n_reg_on;
    logic [7:0]  n_sp;
    logic [3:0]  n_pend;

    logic        r_out_valid;
    logic [13:0] r_out_duty;
    logic [7:0]  r_out_psc;
    logic        r_out_reg;
    logic        r_out_oc;
    logic [7:0]  r_out_sp;

    logic        advance;
    logic        oc;
    logic        done;
    logic [3:0]  pend;
    logic [13:0] cmd_duty;
    logic signed [14:0] duty_dn;
    logic [14:0] duty_up;
    logic signed [ACC_W-1:0] nd;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;

    assign o_take  = !r_out_valid || !i_out_stall;
    assign advance = i_valid && o_take;
    assign oc      = i_item.oc;

    assign duty_dn = $signed({1'b0, r_duty}) - $signed({3'b0, i_cfg.duty_step});
    assign duty_up = {1'b0, r_duty} + {3'b0, i_cfg.duty_step};

    always_comb begin
        pend     = ((i_item.cmd >= CMD_DUTY_DOWN) && (i_item.cmd <= CMD_PSC_DOWN)) ?
                   i_item.cmd : r_pend;
        done     = 1'b0;
        cmd_duty = r_duty;
        n_psc    = r_psc;
        n_reg_on = r_reg_on;
        n_sp     = r_sp;
        unique case (pend)
            CMD_DUTY_DOWN: begin
                if (!r_reg_on && !oc) begin
                    done = 1'b1;
                    if (r_duty > i_cfg.duty_min) begin
                        cmd_duty = (duty_dn < $signed({1'b0, i_cfg.duty_min})) ?
                                   i_cfg.duty_min : duty_dn[13:0];
                    end else begin
                        cmd_duty = i_cfg.duty_min;
                    end
                end
            end
            CMD_DUTY_UP: begin
                if (!r_reg_on && !oc) begin
                    done = 1'b1;
                    if (r_duty < i_cfg.duty_max) begin
                        cmd_duty = (duty_up > {1'b0, i_cfg.duty_max}) ?
                                   i_cfg.duty_max : duty_up[13:0];
                    end else begin
                        cmd_duty = i_cfg.duty_max;
                    end
                end
            end
            CMD_REG_ON: begin
                if (!oc) begin
                    done     = 1'b1;
                    n_reg_on = 1'b1;
                end
            end
            CMD_REG_OFF: begin
                if (!oc) begin
                    done     = 1'b1;
                    n_reg_on = 1'b0;
                    cmd_duty = i_cfg.duty_default;
                end
            end
            CMD_SP_UP: begin
                done = 1'b1;
                if (r_sp != 8'hff) begin
                    n_sp = r_sp + 8'd1;
                end
            end
            CMD_SP_DOWN: begin
                done = 1'b1;
                if (r_sp != 8'h00) begin
                    n_sp = r_sp - 8'd1;
                end
            end
            CMD_PSC_UP: begin
                if (!oc) begin
                    done  = 1'b1;
                    n_psc = (r_psc < i_cfg.psc_max) ? r_psc + 8'd1 : i_cfg.psc_max;
                end
            end
            CMD_PSC_DOWN: begin
                if (!oc) begin
                    done  = 1'b1;
                    n_psc = (r_psc > i_cfg.psc_min) ? r_psc - 8'd1 : i_cfg.psc_min;
                end
            end
            default: begin
                done = 1'b0;
            end
        endcase
        n_pend = done ? CMD_NONE : pend;
    end

    // proportional step toward the setpoint
    assign nd = $signed(ACC_W'(cmd_duty)) + $signed(ACC_W'(n_sp) * ACC_W'(SP_GAIN))
              - $signed(ACC_W'(i_item.corr));
    assign hi = $signed(ACC_W'(i_cfg.duty_max));
    assign lo = $signed(ACC_W'(i_cfg.duty_min));

    always_comb begin
        n_duty = cmd_duty;
        if (n_reg_on && !oc) begin
            priority if (nd > hi) begin
                n_duty = i_cfg.duty_max;
            end else if (nd < lo) begin
                n_duty = i_cfg.duty_min;
            end else begin
                n_duty = nd[13:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty      <= RST_DUTY_DEF;
            r_psc       <= RST_PSC;
            r_reg_on    <= 1'b0;
            r_sp        <= RST_SETPOINT;
            r_pend      <= CMD_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_duty   <= n_duty;
                r_psc    <= n_psc;
                r_reg_on <= n_reg_on;
                r_sp     <= n_sp;
                r_pend   <= n_pend;
            end
            if (o_take) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_duty <= oc ? 14'd0 : n_duty;
            r_out_psc  <= n_psc;
            r_out_reg  <= n_reg_on;
            r_out_oc   <= oc;
            r_out_sp   <= n_sp;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_duty_compare        = r_out_duty;
    assign o_inverter_prescaler  = r_out_psc;
    assign o_regulating          = r_out_reg;
    assign o_overcurrent         = r_out_oc;
    assign o_setpoint_half_volts = r_out_sp;

endmodule

`default_nettype wire

FILE: sv/boost_duty_regulator_with_commands.sv
// ----------------------------------------------------------------------------
// boost_duty_regulator_with_commands
// Boost converter duty regulator with a pending command slot, register file
// on an APB-style port, and one result word per sample word.
//
//   port group   direction  handshake                 payload
//   in           input      i_in_valid / o_in_stall   command, current, voltage
//   out          output     o_out_valid / i_out_stall duty, prescaler, flags, setpoint
//   apb          input      psel / penable / pready   paddr, pwdata, prdata
//
// one word per cycle sustained while the output does not stall; a result word
// passes through the input register, then the loop state and result register,
// before it appears at the output
// the loop state update is a single pass through command logic and the
// proportional adder/clamp between the two registers
// synchronous active-low reset clears state, no clearing pass is needed
// a stalled output holds the result and stalls the input once both stages fill
// ----------------------------------------------------------------------------
`default_nettype none

module boost_duty_regulator_with_commands #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire [3:0]                   i_new_command,
    input  wire [SAMPLE_BITS-1:0]       i_current_sample,
    input  wire [SAMPLE_BITS-1:0]       i_voltage_sample,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic [13:0]                 o_duty_compare,
    output logic [7:0]                  o_inverter_prescaler,
    output logic                        o_regulating,
    output logic                        o_overcurrent,
    output logic [7:0]                  o_setpoint_half_volts,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire [bdr_pkg::ADDR_W-1:0]   paddr,
    input  wire [bdr_pkg::DATA_W-1:0]   pwdata,
    output logic [bdr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import bdr_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;
    logic       fe_valid;
    logic       core_take;
    t_item      fe_item;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.oc_threshold <= RST_OC_THR;
            r_cfg.duty_min     <= RST_DUTY_MIN;
            r_cfg.duty_max     <= RST_DUTY_MAX;
            r_cfg.duty_step    <= RST_DUTY_STEP;
            r_cfg.duty_default <= RST_DUTY_DEF;
            r_cfg.psc_min      <= RST_PSC_MIN;
            r_cfg.psc_max      <= RST_PSC_MAX;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_OC_THR:    r_cfg.oc_threshold <= pwdata[11:0];
                REG_DUTY_MIN:  r_cfg.duty_min     <= pwdata[13:0];
                REG_DUTY_MAX:  r_cfg.duty_max     <= pwdata[13:0];
                REG_DUTY_STEP: r_cfg.duty_step    <= pwdata[11:0];
                REG_DUTY_DEF:  r_cfg.duty_default <= pwdata[13:0];
                REG_PSC_MIN:   r_cfg.psc_min      <= pwdata[7:0];
                REG_PSC_MAX:   r_cfg.psc_max      <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_OC_THR:    prdata = DATA_W'(r_cfg.oc_threshold);
            REG_DUTY_MIN:  prdata = DATA_W'(r_cfg.duty_min);
            REG_DUTY_MAX:  prdata = DATA_W'(r_cfg.duty_max);
            REG_DUTY_STEP: prdata = DATA_W'(r_cfg.duty_step);
            REG_DUTY_DEF:  prdata = DATA_W'(r_cfg.duty_default);
            REG_PSC_MIN:   prdata = DATA_W'(r_cfg.psc_min);
            REG_PSC_MAX:   prdata = DATA_W'(r_cfg.psc_max);
            default:       prdata = '0;
        endcase
    end

    bdr_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in_valid),
        .o_stall          (o_in_stall),
        .i_new_command    (i_new_command),
        .i_current_sample (i_current_sample),
        .i_voltage_sample (i_voltage_sample),
        .i_threshold      (r_cfg.oc_threshold),
        .i_take           (core_take),
        .o_valid          (fe_valid),
        .o_item           (fe_item)
    );

    bdr_core u_core (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg                 (r_cfg),
        .i_valid               (fe_valid),
        .i_item                (fe_item),
        .o_take                (core_take),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_duty_compare        (o_duty_compare),
        .o_inverter_prescaler  (o_inverter_prescaler),
        .o_regulating          (o_regulating),
        .o_overcurrent         (o_overcurrent),
        .o_setpoint_half_volts (o_setpoint_half_volts)
    );

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the boost duty regulator. A clocked driver feeds
// sample words from a queue, a clocked monitor checks every result word
// against a cycle-free model of the command slot, clamps and proportional
// loop. Register settings change between phases, including inverted bounds
// and full-scale values, under several idle and stall patterns.
// ----------------------------------------------------------------------------

module testbench;

    import bdr_pkg::*;

    localparam int SAMPLE_BITS = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_SHOWN = 100;
    localparam logic [3:0] CODE_UNUSED_LO = CMD_PSC_DOWN + 4'd1;
    localparam logic [3:0] CODE_UNUSED_HI = 4'hf;

    typedef struct packed {
        logic [3:0]             cmd;
        logic [SAMPLE_BITS-1:0] cur;
        logic [SAMPLE_BITS-1:0] volt;
    } t_loop_word;

    typedef struct packed {
        logic [13:0] duty;
        logic [7:0]  psc;
        logic        reg_on;
        logic        oc;
        logic [7:0]  sp;
    } t_loop_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [3:0] i_new_command = '0;
    logic [SAMPLE_BITS-1:0] i_current_sample = '0;
    logic [SAMPLE_BITS-1:0] i_voltage_sample = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [13:0] o_duty_compare;
    logic [7:0] o_inverter_prescaler;
    logic o_regulating;
    logic o_overcurrent;
    logic [7:0] o_setpoint_half_volts;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    boost_duty_regulator_with_commands #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) i_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_new_command         (i_new_command),
        .i_current_sample      (i_current_sample),
        .i_voltage_sample      (i_voltage_sample),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_duty_compare        (o_duty_compare),
        .o_inverter_prescaler  (o_inverter_prescaler),
        .o_regulating          (o_regulating),
        .o_overcurrent         (o_overcurrent),
        .o_setpoint_half_volts (o_setpoint_half_volts),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // register copy and loop state of the model
    t_cfg cfg = '{oc_threshold: RST_OC_THR, duty_min: RST_DUTY_MIN, duty_max: RST_DUTY_MAX,
                  duty_step: RST_DUTY_STEP, duty_default: RST_DUTY_DEF,
                  psc_min: RST_PSC_MIN, psc_max: RST_PSC_MAX};
    logic [13:0] duty_now = RST_DUTY_DEF;
    logic [7:0]  psc_now = RST_PSC;
    logic        reg_now = 1'b0;
    logic [7:0]  sp_now = RST_SETPOINT;
    logic [3:0]  cmd_held = CMD_NONE;

    t_loop_word   sample_words[$];
    t_loop_result expected_outputs[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_gen = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int error_count = 0;

    task automatic note_mismatch(input string msg);
        if (error_count < MAX_SHOWN)
            $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic t_loop_result regulate_pass(input t_loop_word w);
        logic oc;
        logic ran;
        longint lo, hi, nd, corr;
        t_loop_result r;
        oc = w.cur > cfg.oc_threshold;
        ran = 1'b0;
        if (w.cmd >= CMD_DUTY_DOWN && w.cmd <= CMD_PSC_DOWN)
            cmd_held = w.cmd;
        case (cmd_held)
            CMD_DUTY_DOWN: if (!reg_now && !oc) begin
                lo = cfg.duty_min;
                if (duty_now > cfg.duty_min) begin
                    nd = longint'(duty_now) - longint'(cfg.duty_step);
                    duty_now = (nd < lo) ? cfg.duty_min : nd[13:0];
                end else begin
                    duty_now = cfg.duty_min;
                end
                ran = 1'b1;
            end
            CMD_DUTY_UP: if (!reg_now && !oc) begin
                hi = cfg.duty_max;
                if (duty_now < cfg.duty_max) begin
                    nd = longint'(duty_now) + longint'(cfg.duty_step);
                    duty_now = (nd > hi) ? cfg.duty_max : nd[13:0];
                end else begin
                    duty_now = cfg.duty_max;
                end
                ran = 1'b1;
            end
            CMD_REG_ON: if (!oc) begin
                reg_now = 1'b1;
                ran = 1'b1;
            end
            CMD_REG_OFF: if (!oc) begin
                reg_now = 1'b0;
                duty_now = cfg.duty_default;
                ran = 1'b1;
            end
            CMD_SP_UP: begin
                if (sp_now != 8'hff)
                    sp_now = sp_now + 8'd1;
                ran = 1'b1;
            end
            CMD_SP_DOWN: begin
                if (sp_now != 8'h00)
                    sp_now = sp_now - 8'd1;
                ran = 1'b1;
            end
            CMD_PSC_UP: if (!oc) begin
                psc_now = (psc_now < cfg.psc_max) ? psc_now + 8'd1 : cfg.psc_max;
                ran = 1'b1;
            end
            CMD_PSC_DOWN: if (!oc) begin
                psc_now = (psc_now > cfg.psc_min) ? psc_now - 8'd1 : cfg.psc_min;
                ran = 1'b1;
            end
            default: ;
        endcase
        if (ran)
            cmd_held = CMD_NONE;
        if (reg_now && !oc) begin
            corr = w.volt;
            corr = (corr * longint'(VOLT_GAIN) + (longint'(1) << SAMPLE_BITS) - 1) >>> SAMPLE_BITS;
            nd = duty_now;
            nd = nd + longint'(SP_GAIN) * longint'(sp_now) - corr;
            lo = cfg.duty_min;
            hi = cfg.duty_max;
            if (nd > hi)
                nd = hi;
            else if (nd < lo)
                nd = lo;
            duty_now = nd[13:0];
        end
        r.duty = oc ? 14'd0 : duty_now;
        r.psc = psc_now;
        r.reg_on = reg_now;
        r.oc = oc;
        r.sp = sp_now;
        return r;
    endfunction

    // sender
    always @(posedge i_clk) begin : drive_words
        t_loop_word w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                w.cmd = i_new_command;
                w.cur = i_current_sample;
                w.volt = i_voltage_sample;
                expected_outputs.push_back(regulate_pass(w));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (sample_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    w = sample_words.pop_front();
                    i_in_valid <= 1'b1;
                    i_new_command <= w.cmd;
                    i_current_sample <= w.cur;
                    i_voltage_sample <= w.volt;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall, with a long hold-off when armed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_seen != hold_gen) begin
            hold_seen <= hold_gen;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin : check_words
        t_loop_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_outputs.size() == 0) begin
                note_mismatch($sformatf("result word with no expectation, duty %0d",
                                        o_duty_compare));
            end else begin
                want = expected_outputs.pop_front();
                if (o_duty_compare !== want.duty)
                    note_mismatch($sformatf("duty_compare got %0d want %0d",
                                            o_duty_compare, want.duty));
                if (o_inverter_prescaler !== want.psc)
                    note_mismatch($sformatf("inverter_prescaler got %0d want %0d",
                                            o_inverter_prescaler, want.psc));
                if (o_regulating !== want.reg_on)
                    note_mismatch($sformatf("regulating got %0b want %0b",
                                            o_regulating, want.reg_on));
                if (o_overcurrent !== want.oc)
                    note_mismatch($sformatf("overcurrent got %0b want %0b",
                                            o_overcurrent, want.oc));
                if (o_setpoint_half_volts !== want.sp)
                    note_mismatch($sformatf("setpoint_half_volts got %0d want %0d",
                                            o_setpoint_half_volts, want.sp));
            end
        end
    end

    task automatic push_word(input logic [3:0] cmd, input logic [SAMPLE_BITS-1:0] cur,
                             input logic [SAMPLE_BITS-1:0] volt);
        t_loop_word w;
        w.cmd = cmd;
        w.cur = cur;
        w.volt = volt;
        sample_words.push_back(w);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_current(input int over_pct);
        int r;
        r = $urandom_range(99);
        if (r < over_pct) begin
            if (cfg.oc_threshold == 12'hfff)
                return 12'hfff;
            return 12'($urandom_range(4095, cfg.oc_threshold + 1));
        end
        if (r < over_pct + 10)
            return 12'($urandom_range(4095));
        return 12'($urandom_range(cfg.oc_threshold, 0));
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_voltage(input bit near);
        longint v;
        int j;
        if (!near)
            return 12'($urandom_range(4095));
        v = sp_now;
        v = (v * longint'(SP_GAIN) * 4096) / longint'(VOLT_GAIN);
        j = $urandom_range(128);
        v = v + j - 64;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v[SAMPLE_BITS-1:0];
    endfunction

    task automatic queue_random_words(input int n);
        int made, kind, len;
        made = 0;
        while (made < n) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                len = $urandom_range(6, 1);
                repeat (len)
                    push_word(4'($urandom_range(CMD_PSC_DOWN, CMD_NONE)), pick_current(10),
                              pick_voltage(0));
            end else if (kind < 70) begin
                len = $urandom_range(10, 3);
                push_word(CMD_REG_ON, pick_current(5), pick_voltage(1));
                repeat (len)
                    push_word(($urandom_range(3) == 0) ?
                              4'($urandom_range(CMD_PSC_DOWN, CMD_DUTY_DOWN)) : CMD_NONE,
                              pick_current(5), pick_voltage($urandom_range(4) != 0));
                push_word(CMD_REG_OFF, pick_current(5), pick_voltage(1));
                len += 2;
            end else if (kind < 85) begin
                len = $urandom_range(4, 1);
                repeat (len)
                    push_word(4'($urandom_range(CMD_PSC_DOWN, CMD_NONE)), pick_current(100),
                              pick_voltage(0));
                push_word(CMD_NONE, pick_current(0), pick_voltage(0));
                len += 1;
            end else begin
                len = $urandom_range(3, 1);
                repeat (len)
                    push_word(4'($urandom_range(CODE_UNUSED_HI, CMD_NONE)),
                              12'($urandom_range(4095)), 12'($urandom_range(4095)));
            end
            made += len;
        end
    endtask

    task automatic wait_drained();
        while (sample_words.size() != 0 || i_in_valid || expected_outputs.size() != 0)
            @(negedge i_clk);
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_OC_THR:    cfg.oc_threshold = val[11:0];
            REG_DUTY_MIN:  cfg.duty_min = val[13:0];
            REG_DUTY_MAX:  cfg.duty_max = val[13:0];
            REG_DUTY_STEP: cfg.duty_step = val[11:0];
            REG_DUTY_DEF:  cfg.duty_default = val[13:0];
            REG_PSC_MIN:   cfg.psc_min = val[7:0];
            REG_PSC_MAX:   cfg.psc_max = val[7:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input t_cfg c);
        write_reg(REG_OC_THR, DATA_W'(c.oc_threshold));
        write_reg(REG_DUTY_MIN, DATA_W'(c.duty_min));
        write_reg(REG_DUTY_MAX, DATA_W'(c.duty_max));
        write_reg(REG_DUTY_STEP, DATA_W'(c.duty_step));
        write_reg(REG_DUTY_DEF, DATA_W'(c.duty_default));
        write_reg(REG_PSC_MIN, DATA_W'(c.psc_min));
        write_reg(REG_PSC_MAX, DATA_W'(c.psc_max));
        @(negedge i_clk);
    endtask

    initial begin : run_phases
        t_cfg c;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings, no idling
        push_word(CMD_NONE, 12'd0, 12'd0);
        push_word(CMD_DUTY_UP, 12'd0, 12'hfff);
        push_word(CMD_DUTY_DOWN, 12'hfff, 12'd0);
        push_word(CMD_NONE, 12'd100, 12'd2000);
        push_word(CMD_PSC_UP, 12'd3724, 12'd1);
        push_word(CODE_UNUSED_LO, 12'd3723, 12'hfff);
        push_word(CMD_PSC_DOWN, 12'd0, 12'd0);
        push_word(CMD_SP_UP, 12'hfff, 12'd0);
        push_word(CMD_SP_DOWN, 12'd0, 12'd0);
        push_word(CMD_REG_ON, 12'hfff, 12'd2750);
        push_word(CMD_NONE, 12'd0, 12'd2750);
        push_word(CMD_DUTY_UP, 12'd0, 12'd2700);
        push_word(CMD_NONE, 12'd0, 12'd0);
        push_word(CMD_NONE, 12'hfff, 12'd0);
        push_word(CMD_NONE, 12'd0, 12'hfff);
        push_word(CODE_UNUSED_HI, 12'd0, 12'hfff);
        push_word(CMD_REG_OFF, 12'd4000, 12'd0);
        push_word(CMD_REG_OFF, 12'd0, 12'd0);
        push_word(CMD_DUTY_DOWN, 12'd0, 12'd0);
        wait_drained();

        // full-range settings, sender idling
        c.oc_threshold = 12'd0;
        c.duty_min = 14'd0;
        c.duty_max = 14'h3fff;
        c.duty_step = 12'hfff;
        c.duty_default = 14'h3fff;
        c.psc_min = 8'd0;
        c.psc_max = 8'hff;
        load_settings(c);
        send_idle_pct = 48;
        stall_pct = 0;
        repeat (60)
            push_word(CMD_SP_DOWN, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
        queue_random_words(30);
        wait_drained();

        // inverted bounds, receiver stalling
        c.oc_threshold = 12'hfff;
        c.duty_min = 14'h3fff;
        c.duty_max = 14'd0;
        c.duty_step = 12'd1;
        c.duty_default = 14'd0;
        c.psc_min = 8'hff;
        c.psc_max = 8'd0;
        load_settings(c);
        send_idle_pct = 0;
        stall_pct = 48;
        repeat (260)
            push_word(CMD_SP_UP, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
        queue_random_words(20);
        wait_drained();

        // random settings, both sides idling, with a full drain halfway
        c.oc_threshold = 12'($urandom_range(4095));
        c.duty_min = 14'($urandom_range(4000));
        c.duty_max = 14'($urandom_range(16383, 8000));
        c.duty_step = 12'($urandom_range(4095, 1));
        c.duty_default = 14'($urandom_range(16383));
        c.psc_min = 8'($urandom_range(20));
        c.psc_max = 8'($urandom_range(255, 20));
        load_settings(c);
        send_idle_pct = 34;
        stall_pct = 34;
        queue_random_words(20);
        wait_drained();
        queue_random_words(20);
        wait_drained();

        // reset values again, no idling, long receiver hold-off
        c.oc_threshold = RST_OC_THR;
        c.duty_min = RST_DUTY_MIN;
        c.duty_max = RST_DUTY_MAX;
        c.duty_step = RST_DUTY_STEP;
        c.duty_default = RST_DUTY_DEF;
        c.psc_min = RST_PSC_MIN;
        c.psc_max = RST_PSC_MAX;
        load_settings(c);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_gen = hold_gen + 1;
        queue_random_words(30);
        wait_drained();

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
sv/bdr_pkg.sv
sv/bdr_front.sv
sv/bdr_core.sv
sv/boost_duty_regulator_with_commands.sv
verif/testbench.sv
